### sv/lsc_pkg.sv
// ----------------------------------------------------------------------------
// lsc_pkg
// Shared types and constants of the grid line-of-sight checker.
// ----------------------------------------------------------------------------
package lsc_pkg;

    localparam int COORD_W   = 8;
    localparam int DIV_STEPS = COORD_W;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct packed {
        logic   done;
        t_coord quo;
        t_coord rem;
    } t_div_res;

endpackage

### sv/lsc_divider.sv
// ----------------------------------------------------------------------------
// lsc_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsc_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  lsc_pkg::t_coord    i_num,
    input  lsc_pkg::t_coord    i_den,
    output lsc_pkg::t_div_res  o_res
);

    localparam int CNT_W = $clog2(lsc_pkg::DIV_STEPS + 1);

    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_done, n_done;
    lsc_pkg::t_coord   r_quo, n_quo;
    lsc_pkg::t_coord   r_rem, n_rem;
    lsc_pkg::t_coord   r_den, n_den;
    logic [lsc_pkg::COORD_W:0] w_trial;
    logic [lsc_pkg::COORD_W:0] w_diff;
    logic              w_ge;

    assign w_trial = {r_rem, r_quo[lsc_pkg::COORD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_comb begin
        n_cnt  = r_cnt;
        n_done = 1'b0;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_cnt = CNT_W'(lsc_pkg::DIV_STEPS);
            n_quo = i_num;
            n_rem = '0;
            n_den = i_den;
        end else if (r_cnt != '0) begin
            n_cnt = r_cnt - 1'b1;
            n_quo = {r_quo[lsc_pkg::COORD_W-2:0], w_ge};
            n_rem = w_ge ? w_diff[lsc_pkg::COORD_W-1:0]
                         : w_trial[lsc_pkg::COORD_W-1:0];
            n_done = (r_cnt == CNT_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_res.done = r_done;
    assign o_res.quo  = r_quo;
    assign o_res.rem  = r_rem;

endmodule

### sv/lsc_map_mem.sv
// ----------------------------------------------------------------------------
// lsc_map_mem
// One-bit obstacle map: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lsc_map_mem #(
    parameter int AW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic          o_rdata
);

    logic r_mem [2**AW];
    logic r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sv/grid_line_of_sight_check_core.sv
// ----------------------------------------------------------------------------
// grid_line_of_sight_check_core
// Obstacle map with write and straight-segment line-of-sight query words.
// ----------------------------------------------------------------------------
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_ready  | i_action i_src_x i_src_y i_dst_x
//         |           |                    | i_dst_y i_blocked
// result  | out       | o_valid / i_ready  | o_clear (queries only)
//
// After reset the map is cleared one entry a cycle, all 2**(XW+YW) entries
// (65536 at the default 256 x 256 grid); o_ready stays low meanwhile.
// A write word is written to the map as it is accepted. A query runs one
// divider pass per nonempty walk, and the single map read port walks one
// cell a cycle; o_ready stays low until the query result is registered.
// A finished result waits in the output register; new words are taken meanwhile.
// ----------------------------------------------------------------------------
module grid_line_of_sight_check_core #(
    parameter int GRID_WIDTH  = 256,
    parameter int GRID_HEIGHT = 256
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic            i_action,
    input  lsc_pkg::t_coord i_src_x,
    input  lsc_pkg::t_coord i_src_y,
    input  lsc_pkg::t_coord i_dst_x,
    input  lsc_pkg::t_coord i_dst_y,
    input  logic            i_blocked,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_clear
);

    localparam int CW = lsc_pkg::COORD_W;
    localparam int XD = (GRID_WIDTH < 2**CW) ? GRID_WIDTH : 2**CW;
    localparam int YD = (GRID_HEIGHT < 2**CW) ? GRID_HEIGHT : 2**CW;
    localparam int XW = $clog2(XD);
    localparam int YW = $clog2(YD);
    localparam int AW = XW + YW;

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV1  = 3'd2;
    localparam logic [2:0] S_WALK1 = 3'd3;
    localparam logic [2:0] S_DIV2  = 3'd4;
    localparam logic [2:0] S_WALK2 = 3'd5;
    localparam logic [2:0] S_DRAIN = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]      r_state, n_state;
    logic [AW-1:0]   r_init_addr, n_init_addr;
    lsc_pkg::t_coord r_sx, n_sx, r_sy, n_sy;
    lsc_pkg::t_coord r_adx, n_adx, r_ady, n_ady;
    logic            r_xneg, n_xneg, r_yneg, n_yneg;
    lsc_pkg::t_coord r_maj, n_maj, r_mnb, n_mnb;
    logic            r_majneg, n_majneg, r_mneg, n_mneg, r_axis, n_axis;
    lsc_pkg::t_coord r_i, n_i, r_q, n_q, r_r, n_r, r_a, n_a;
    lsc_pkg::t_coord r_qd, n_qd, r_rd, n_rd;
    logic            r_ok, n_ok;
    logic            r_chk_vld, n_chk_vld, r_chk_oob, n_chk_oob;
    logic            r_out_vld, n_out_vld, r_out_clr, n_out_clr;

    logic              w_in_acc, w_issue;
    logic              w_div_start;
    lsc_pkg::t_coord   w_div_num, w_div_den;
    lsc_pkg::t_div_res w_div;
    lsc_pkg::t_coord   w_adx, w_ady, w_off, w_minor, w_cx, w_cy;
    logic [CW:0]       w_rsum;
    logic              w_ge;
    logic              w_we, w_wdata, w_rdata;
    logic [AW-1:0]     w_waddr, w_raddr;

    assign o_ready  = (r_state == S_IDLE);
    assign w_in_acc = i_valid && o_ready;
    assign w_adx    = (i_dst_x >= i_src_x) ? i_dst_x - i_src_x : i_src_x - i_dst_x;
    assign w_ady    = (i_dst_y >= i_src_y) ? i_dst_y - i_src_y : i_src_y - i_dst_y;

    // current walk cell
    assign w_off   = r_q + CW'(r_mneg && (r_r != '0));
    assign w_minor = r_mneg ? r_mnb - w_off : r_mnb + w_off;
    assign w_cx    = r_axis ? w_minor : r_maj;
    assign w_cy    = r_axis ? r_maj : w_minor;
    assign w_raddr = {w_cy[YW-1:0], w_cx[XW-1:0]};
    assign w_issue = (r_state == S_WALK1) || (r_state == S_WALK2);

    assign w_rsum = {1'b0, r_r} + {1'b0, r_rd};
    assign w_ge   = w_rsum >= {1'b0, r_a};

    always_comb begin
        n_state     = r_state;
        n_init_addr = r_init_addr;
        n_sx = r_sx;   n_sy = r_sy;
        n_adx = r_adx; n_ady = r_ady;
        n_xneg = r_xneg; n_yneg = r_yneg;
        n_maj = r_maj; n_mnb = r_mnb;
        n_majneg = r_majneg; n_mneg = r_mneg; n_axis = r_axis;
        n_i = r_i; n_q = r_q; n_r = r_r; n_a = r_a;
        n_qd = r_qd; n_rd = r_rd;
        n_ok = r_ok;
        n_out_vld = r_out_vld;
        n_out_clr = r_out_clr;
        w_div_start = 1'b0;
        w_div_num   = r_ady;
        w_div_den   = r_adx;
        w_we    = 1'b0;
        w_waddr = {i_src_y[YW-1:0], i_src_x[XW-1:0]};
        w_wdata = i_blocked;

        if (r_out_vld && i_ready) begin
            n_out_vld = 1'b0;
        end

        n_chk_vld = w_issue;
        n_chk_oob = (32'(w_cx) >= GRID_WIDTH) || (32'(w_cy) >= GRID_HEIGHT);
        if (r_chk_vld && (r_chk_oob || w_rdata)) begin
            n_ok = 1'b0;
        end

        unique case (r_state)
            S_INIT: begin
                w_we        = 1'b1;
                w_waddr     = r_init_addr;
                w_wdata     = 1'b0;
                n_init_addr = r_init_addr + 1'b1;
                if (r_init_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    if (i_action == lsc_pkg::ACT_WRITE) begin
                        w_we = (32'(i_src_x) < GRID_WIDTH) && (32'(i_src_y) < GRID_HEIGHT);
                    end else begin
                        n_sx   = i_src_x;
                        n_sy   = i_src_y;
                        n_adx  = w_adx;
                        n_ady  = w_ady;
                        n_xneg = i_dst_x < i_src_x;
                        n_yneg = i_dst_y < i_src_y;
                        n_ok   = 1'b1;
                        if (w_adx != '0) begin
                            w_div_start = 1'b1;
                            w_div_num   = w_ady;
                            w_div_den   = w_adx;
                            n_state     = S_DIV1;
                        end else if (w_ady != '0) begin
                            w_div_start = 1'b1;
                            w_div_num   = w_adx;
                            w_div_den   = w_ady;
                            n_state     = S_DIV2;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_DIV1: begin
                if (w_div.done) begin
                    n_qd = w_div.quo;  n_rd = w_div.rem;
                    n_q = '0; n_r = '0; n_i = '0;
                    n_a = r_adx;
                    n_maj = r_sx; n_majneg = r_xneg;
                    n_mnb = r_sy; n_mneg = r_yneg;
                    n_axis = 1'b0;
                    n_state = S_WALK1;
                end
            end
            S_DIV2: begin
                if (w_div.done) begin
                    n_qd = w_div.quo;  n_rd = w_div.rem;
                    n_q = '0; n_r = '0; n_i = '0;
                    n_a = r_ady;
                    n_maj = r_sy; n_majneg = r_yneg;
                    n_mnb = r_sx; n_mneg = r_xneg;
                    n_axis = 1'b1;
                    n_state = S_WALK2;
                end
            end
            S_WALK1, S_WALK2: begin
                n_maj = r_majneg ? r_maj - 1'b1 : r_maj + 1'b1;
                n_i   = r_i + 1'b1;
                n_r   = w_ge ? CW'(w_rsum - {1'b0, r_a}) : w_rsum[CW-1:0];
                n_q   = r_q + r_qd + CW'(w_ge);
                if (r_i == r_a - 1'b1) begin
                    if ((r_state == S_WALK1) && (r_ady != '0)) begin
                        w_div_start = 1'b1;
                        w_div_num   = r_adx;
                        w_div_den   = r_ady;
                        n_state     = S_DIV2;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_vld || i_ready) begin
                    n_out_vld = 1'b1;
                    n_out_clr = r_ok;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_addr <= '0;
            r_chk_vld   <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_addr <= n_init_addr;
            r_chk_vld   <= n_chk_vld;
            r_out_vld   <= n_out_vld;
        end
        r_sx <= n_sx;   r_sy <= n_sy;
        r_adx <= n_adx; r_ady <= n_ady;
        r_xneg <= n_xneg; r_yneg <= n_yneg;
        r_maj <= n_maj; r_mnb <= n_mnb;
        r_majneg <= n_majneg; r_mneg <= n_mneg; r_axis <= n_axis;
        r_i <= n_i; r_q <= n_q; r_r <= n_r; r_a <= n_a;
        r_qd <= n_qd; r_rd <= n_rd;
        r_ok <= n_ok;
        r_chk_oob <= n_chk_oob;
        r_out_clr <= n_out_clr;
    end

    lsc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_res   (w_div)
    );

    lsc_map_mem #(.AW(AW)) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign o_valid = r_out_vld;
    assign o_clear = r_out_clr;

    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !o_ready)
        else $error("word accepted during map clear");

    a_null_query_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_action == lsc_pkg::ACT_QUERY) && (i_src_x == i_dst_x)
         && (i_src_y == i_dst_y)) |=> (r_state == S_DONE) && r_ok)
        else $error("empty query not finished clear");

    a_check_from_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_vld |-> ($past(r_state) == S_WALK1) || ($past(r_state) == S_WALK2))
        else $error("map check without a walk read");

    a_done_after_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> !r_chk_vld)
        else $error("result taken before last map read checked");

endmodule

### verif/grid_line_of_sight_check_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_line_of_sight_check_core_tb
// Drives map write and line-of-sight query words through the core with
// random idling on both channels. A scoreboard keeps its own obstacle map,
// walks each queried segment itself and checks every clear bit in order.
// ----------------------------------------------------------------------------
module grid_line_of_sight_check_core_tb;

    localparam int GRID_W    = 256;
    localparam int GRID_H    = 256;
    localparam int N_RANDOM  = 1150;
    localparam int TAIL_CYC  = 600;

    typedef struct packed {
        logic            action;
        lsc_pkg::t_coord src_x;
        lsc_pkg::t_coord src_y;
        lsc_pkg::t_coord dst_x;
        lsc_pkg::t_coord dst_y;
        logic            blocked;
    } t_map_word;

    class t_los_board;
        bit obstacle [GRID_W*GRID_H];
        bit pending_clear [$];
        int mismatches;
        int n_writes;
        int n_queries;
        int n_obstructed;
        int n_results;

        function bit cell_hit(int x, int y);
            if (x < 0 || y < 0 || x >= GRID_W || y >= GRID_H)
                return 1'b1;
            return obstacle[y*GRID_W + x];
        endfunction

        function int floor_div(int num, int den);
            if (num >= 0)
                return num / den;
            return -(((-num) + den - 1) / den);
        endfunction

        function bit path_is_clear(int sx, int sy, int tx, int ty);
            int ddx;
            int ddy;
            int sgx;
            int sgy;
            int adx;
            int ady;
            int i;
            ddx = tx - sx;
            ddy = ty - sy;
            sgx = (ddx < 0) ? -1 : 1;
            sgy = (ddy < 0) ? -1 : 1;
            adx = ddx * sgx;
            ady = ddy * sgy;
            if (ddx == 0) begin
                for (i = 0; i < ady; i++)
                    if (cell_hit(sx, sy + sgy*i)) return 1'b0;
                return 1'b1;
            end
            if (ddy == 0) begin
                for (i = 0; i < adx; i++)
                    if (cell_hit(sx + sgx*i, sy)) return 1'b0;
                return 1'b1;
            end
            for (i = 0; i < adx; i++)
                if (cell_hit(sx + sgx*i, sy + floor_div(ddy*i, adx))) return 1'b0;
            for (i = 0; i < ady; i++)
                if (cell_hit(sx + floor_div(ddx*i, ady), sy + sgy*i)) return 1'b0;
            return 1'b1;
        endfunction

        function void take_word(t_map_word w);
            bit c;
            if (w.action == lsc_pkg::ACT_WRITE) begin
                n_writes++;
                if (int'(w.src_x) < GRID_W && int'(w.src_y) < GRID_H)
                    obstacle[int'(w.src_y)*GRID_W + int'(w.src_x)] = w.blocked;
            end else begin
                n_queries++;
                c = path_is_clear(int'(w.src_x), int'(w.src_y),
                                  int'(w.dst_x), int'(w.dst_y));
                if (!c) n_obstructed++;
                pending_clear.insert(pending_clear.size(), c);
            end
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void check_clear(logic got);
            bit exp;
            n_results++;
            if (pending_clear.size() == 0) begin
                flag($sformatf("unexpected result word, clear=%b", got));
            end else begin
                exp = pending_clear.pop_front();
                if (got !== exp)
                    flag($sformatf("result %0d clear expected %b actual %b",
                                   n_results, exp, got));
            end
        endfunction
    endclass

    logic            i_clk;
    logic            i_rst_n;
    logic            i_valid;
    logic            o_ready;
    logic            i_action;
    lsc_pkg::t_coord i_src_x;
    lsc_pkg::t_coord i_src_y;
    lsc_pkg::t_coord i_dst_x;
    lsc_pkg::t_coord i_dst_y;
    logic            i_blocked;
    logic            o_valid;
    logic            i_ready;
    logic            o_clear;

    t_los_board board;
    bit         send_calm;
    bit         recv_calm;
    int         win_x;
    int         win_y;
    int         win_sz;

    grid_line_of_sight_check_core #(
        .GRID_WIDTH  (GRID_W),
        .GRID_HEIGHT (GRID_H)
    ) u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_action  (i_action),
        .i_src_x   (i_src_x),
        .i_src_y   (i_src_y),
        .i_dst_x   (i_dst_x),
        .i_dst_y   (i_dst_y),
        .i_blocked (i_blocked),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_clear   (o_clear)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic int pick_gap(inout bit calm);
        if ($urandom_range(0, 39) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    function automatic t_map_word mk(logic a, int sx, int sy, int tx, int ty, logic b);
        t_map_word w;
        w.action  = a;
        w.src_x   = lsc_pkg::t_coord'(sx);
        w.src_y   = lsc_pkg::t_coord'(sy);
        w.dst_x   = lsc_pkg::t_coord'(tx);
        w.dst_y   = lsc_pkg::t_coord'(ty);
        w.blocked = b;
        return w;
    endfunction

    function automatic lsc_pkg::t_coord in_win(int base);
        return lsc_pkg::t_coord'(base + $urandom_range(0, win_sz - 1));
    endfunction

    function automatic lsc_pkg::t_coord near(lsc_pkg::t_coord c);
        int v;
        v = int'(c) + $urandom_range(0, 6) - 3;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return lsc_pkg::t_coord'(v);
    endfunction

    function automatic t_map_word random_word();
        t_map_word w;
        int r;
        r = $urandom_range(0, 99);
        w.action  = lsc_pkg::ACT_QUERY;
        w.blocked = 1'($urandom_range(0, 1));
        w.src_x   = lsc_pkg::t_coord'($urandom_range(0, 255));
        w.src_y   = lsc_pkg::t_coord'($urandom_range(0, 255));
        w.dst_x   = lsc_pkg::t_coord'($urandom_range(0, 255));
        w.dst_y   = lsc_pkg::t_coord'($urandom_range(0, 255));
        if (r < 40) begin
            w.action  = lsc_pkg::ACT_WRITE;
            w.blocked = ($urandom_range(0, 9) < 3);
            if ($urandom_range(0, 4) != 0) begin
                w.src_x = in_win(win_x);
                w.src_y = in_win(win_y);
            end
        end else if (r < 70) begin
            w.src_x = in_win(win_x);
            w.src_y = in_win(win_y);
            w.dst_x = in_win(win_x);
            w.dst_y = in_win(win_y);
        end else if (r < 80) begin
            w.src_x = in_win(win_x);
            w.src_y = in_win(win_y);
            if ($urandom_range(0, 1)) begin
                w.dst_x = w.src_x;
                w.dst_y = in_win(win_y);
            end else begin
                w.dst_y = w.src_y;
                w.dst_x = in_win(win_x);
            end
        end else if (r < 86) begin
            w.dst_x = w.src_x;
            w.dst_y = w.src_y;
        end else if (r < 94) begin
            w.src_x = in_win(win_x);
            w.src_y = in_win(win_y);
            w.dst_x = near(w.src_x);
            w.dst_y = near(w.src_y);
        end
        return w;
    endfunction

    task automatic send_word(input t_map_word w);
        int gap;
        @(negedge i_clk);
        gap = pick_gap(send_calm);
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action  = w.action;
        i_src_x   = w.src_x;
        i_src_y   = w.src_y;
        i_dst_x   = w.dst_x;
        i_dst_y   = w.dst_y;
        i_blocked = w.blocked;
        i_valid   = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        board.take_word(w);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (board.pending_clear.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_directed();
        send_word(mk(lsc_pkg::ACT_QUERY,   0,   0,   0,   0, 1'b0));
        send_word(mk(lsc_pkg::ACT_QUERY, 255, 255, 255, 255, 1'b1));
        send_word(mk(lsc_pkg::ACT_QUERY,   0,   0, 255, 255, 1'b0));
        send_word(mk(lsc_pkg::ACT_QUERY, 255,   0,   0, 255, 1'b0));
        send_word(mk(lsc_pkg::ACT_WRITE, 255, 255, 255, 255, 1'b1));
        send_word(mk(lsc_pkg::ACT_QUERY, 255, 255,   0,   0, 1'b0));
        send_word(mk(lsc_pkg::ACT_QUERY,   0,   0, 255, 255, 1'b0));
        send_word(mk(lsc_pkg::ACT_WRITE,  10,   5,   0,   0, 1'b1));
        send_word(mk(lsc_pkg::ACT_QUERY,   0,   5,  20,   5, 1'b0));
        send_word(mk(lsc_pkg::ACT_QUERY,  20,   5,  10,   5, 1'b0));
        send_word(mk(lsc_pkg::ACT_QUERY,  10,   5,  20,   5, 1'b1));
        send_word(mk(lsc_pkg::ACT_WRITE,   7, 200, 128, 127, 1'b1));
        send_word(mk(lsc_pkg::ACT_QUERY,   7, 255,   7,   0, 1'b0));
        send_word(mk(lsc_pkg::ACT_QUERY,   7,   0,   7, 200, 1'b0));
        send_word(mk(lsc_pkg::ACT_WRITE,   5,  17,   0,   0, 1'b1));
        send_word(mk(lsc_pkg::ACT_QUERY,  12,   0,   0,  30, 1'b0));
        send_word(mk(lsc_pkg::ACT_QUERY,   0,  30,  12,   0, 1'b0));
        send_word(mk(lsc_pkg::ACT_QUERY, 100, 100, 101, 200, 1'b0));
        send_word(mk(lsc_pkg::ACT_QUERY,   3,   2, 200,   3, 1'b0));
        send_word(mk(lsc_pkg::ACT_WRITE, 255, 255,   0,   0, 1'b0));
        send_word(mk(lsc_pkg::ACT_QUERY, 255, 255,   0,   0, 1'b1));
        send_word(mk(lsc_pkg::ACT_WRITE,   0,   0,   0,   0, 1'b1));
        send_word(mk(lsc_pkg::ACT_QUERY,   0,   0,   1,   0, 1'b0));
        send_word(mk(lsc_pkg::ACT_QUERY,   1,   0,   0,   0, 1'b0));
    endtask

    initial begin : result_side
        int gap;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            gap = pick_gap(recv_calm);
            if (gap > 0) begin
                i_ready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready = 1'b1;
            do @(posedge i_clk); while (!o_valid);
            board.check_clear(o_clear);
        end
    end

    initial begin : stimulus
        int k;
        board     = new();
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_action  = lsc_pkg::ACT_WRITE;
        i_src_x   = '0;
        i_src_y   = '0;
        i_dst_x   = '0;
        i_dst_y   = '0;
        i_blocked = 1'b0;
        send_calm = 1'b0;
        recv_calm = 1'b0;
        win_x     = 0;
        win_y     = 0;
        win_sz    = 32;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();
        wait_drained();

        for (k = 0; k < N_RANDOM; k++) begin
            if (k % 150 == 0) begin
                win_sz = $urandom_range(0, 1) ? 16 : 32;
                case ($urandom_range(0, 3))
                    0: begin
                        win_x = 0;
                        win_y = 256 - win_sz;
                    end
                    1: begin
                        win_x = 256 - win_sz;
                        win_y = 256 - win_sz;
                    end
                    default: begin
                        win_x = $urandom_range(0, 256 - win_sz);
                        win_y = $urandom_range(0, 256 - win_sz);
                    end
                endcase
            end
            if (k == N_RANDOM / 2) wait_drained();
            send_word(random_word());
        end
        wait_drained();
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("covered %0d map writes and %0d queries, %0d of them obstructed",
                 board.n_writes, board.n_queries, board.n_obstructed);
        $display("%0d result words checked, %0d mismatches",
                 board.n_results, board.mismatches);
        if (board.mismatches == 0 && board.pending_clear.size() == 0) begin
            $display("grid_line_of_sight_check_core_tb: PASS");
        end else begin
            $display("grid_line_of_sight_check_core_tb: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #12_000_000;
        $display("grid_line_of_sight_check_core_tb: FAIL");
        $finish;
    end

endmodule
